[src/ddm_pkg.sv]
// Shared types, widths and reset values for the differential drive mixer.
// Used by ddm_cfg, ddm_div and diff_drive_mixer_with_timeout_unit.
`default_nettype none

package ddm_pkg;

	// Default fraction bits of the velocity and track formats
	localparam int VEL_FRAC_BITS_DEF = 12;

	// Fixed field widths
	localparam int VEL_W   = 16;
	localparam int TRACK_W = 16;
	localparam int MAXS_W  = 16;
	localparam int DZ_W    = 15;
	localparam int TO_W    = 16;
	localparam int PER_W   = 10;
	localparam int CMD_W   = 16;
	localparam int AGE_W   = 16;
	localparam int Q_W     = 15;
	localparam int DEN_W   = MAXS_W + 1;
	localparam int CFG_AW  = 3;
	localparam int CFG_DW  = 16;

	// Register indexes
	localparam logic [CFG_AW-1:0] REG_TRACK   = 3'd0;
	localparam logic [CFG_AW-1:0] REG_MAXS    = 3'd1;
	localparam logic [CFG_AW-1:0] REG_DZ      = 3'd2;
	localparam logic [CFG_AW-1:0] REG_TIMEOUT = 3'd3;
	localparam logic [CFG_AW-1:0] REG_PERIOD  = 3'd4;

	// Register reset values
	localparam logic [TRACK_W-1:0] TRACK_RST   = 16'd2458;
	localparam logic [MAXS_W-1:0]  MAXS_RST    = 16'd4096;
	localparam logic [DZ_W-1:0]    DZ_RST      = 15'd1638;
	localparam logic [TO_W-1:0]    TIMEOUT_RST = 16'd250;
	localparam logic [PER_W-1:0]   PERIOD_RST  = 10'd50;

	// Input opcodes
	localparam logic OP_CMD  = 1'b0;
	localparam logic OP_TICK = 1'b1;

	// Largest normalized magnitude
	localparam logic [Q_W-1:0] Q_MAX = 15'h7FFF;

	typedef struct packed {
		logic [TRACK_W-1:0] wheel_base;
		logic [MAXS_W-1:0]  max_wheel_speed;
		logic [DZ_W-1:0]    deadzone;
		logic [TO_W-1:0]    stale_limit;
		logic [PER_W-1:0]   publish_period_ms;
	} cfg_t;

	typedef struct packed {
		logic           done;
		logic           sat;
		logic [Q_W-1:0] quo;
	} div_rsp_t;

endpackage

`default_nettype wire

[src/ddm_cfg.sv]
// Configuration register file of the mixer: decode of the write port.
// Depends on ddm_pkg for register indexes, widths and reset values.
`default_nettype none

module ddm_cfg (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         we,
	input  wire [ddm_pkg::CFG_AW-1:0]   addr,
	input  wire [ddm_pkg::CFG_DW-1:0]   wdata,
	output ddm_pkg::cfg_t               cfg
);

	ddm_pkg::cfg_t cfg_q;

	// Write the addressed register; drop writes beyond the list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.wheel_base        <= ddm_pkg::TRACK_RST;
			cfg_q.max_wheel_speed   <= ddm_pkg::MAXS_RST;
			cfg_q.deadzone          <= ddm_pkg::DZ_RST;
			cfg_q.stale_limit       <= ddm_pkg::TIMEOUT_RST;
			cfg_q.publish_period_ms <= ddm_pkg::PERIOD_RST;
		end else if (we) begin
			case (addr)
				ddm_pkg::REG_TRACK:   cfg_q.wheel_base <= wdata[ddm_pkg::TRACK_W-1:0];
				ddm_pkg::REG_MAXS:    cfg_q.max_wheel_speed <= wdata[ddm_pkg::MAXS_W-1:0];
				ddm_pkg::REG_DZ:      cfg_q.deadzone <= wdata[ddm_pkg::DZ_W-1:0];
				ddm_pkg::REG_TIMEOUT: cfg_q.stale_limit <= wdata[ddm_pkg::TO_W-1:0];
				ddm_pkg::REG_PERIOD:  cfg_q.publish_period_ms <= wdata[ddm_pkg::PER_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

[src/ddm_div.sv]
// Shared restoring divider with early saturation, one quotient bit a cycle.
// Depends on ddm_pkg for the quotient and divisor widths and the response struct.
`default_nettype none

module ddm_div #(
	parameter int NUM_W = 38
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        start,
	input  wire [NUM_W-1:0]            num,
	input  wire [ddm_pkg::DEN_W-1:0]   den,
	output ddm_pkg::div_rsp_t          rsp
);

	localparam int HI_W  = NUM_W - ddm_pkg::Q_W;
	localparam int CNT_W = $clog2(ddm_pkg::Q_W);
	localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(ddm_pkg::Q_W - 1);

	localparam logic [1:0] D_IDLE  = 2'd0;
	localparam logic [1:0] D_CHECK = 2'd1;
	localparam logic [1:0] D_STEP  = 2'd2;

	logic [1:0]                 state_q;
	logic [CNT_W-1:0]           cnt_q;
	logic [HI_W-1:0]            rem_q;
	logic [ddm_pkg::Q_W-1:0]    lo_q;
	logic [ddm_pkg::DEN_W-1:0]  den_q;
	logic                       done_q;
	logic                       sat_q;

	logic [ddm_pkg::DEN_W:0]    trial;
	logic [ddm_pkg::DEN_W:0]    diff;
	logic                       qbit;

	// Shift in the next dividend bit and try the subtraction
	assign trial = {rem_q[ddm_pkg::DEN_W-1:0], lo_q[ddm_pkg::Q_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign qbit  = (trial >= {1'b0, den_q});

	// Control: load, saturation check, then one bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
			sat_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				D_IDLE: begin
					if (start) begin
						state_q <= D_CHECK;
					end
				end
				D_CHECK: begin
					cnt_q <= '0;
					if (rem_q >= HI_W'(den_q)) begin
						sat_q   <= 1'b1;
						done_q  <= 1'b1;
						state_q <= D_IDLE;
					end else begin
						sat_q   <= 1'b0;
						state_q <= D_STEP;
					end
				end
				D_STEP: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LAST_STEP) begin
						done_q  <= 1'b1;
						state_q <= D_IDLE;
					end
				end
				default: state_q <= D_IDLE;
			endcase
		end
	end

	// Datapath: remainder and dividend/quotient shift register
	always_ff @(posedge clk) begin
		if (state_q == D_IDLE && start) begin
			rem_q <= num[NUM_W-1:ddm_pkg::Q_W];
			lo_q  <= num[ddm_pkg::Q_W-1:0];
			den_q <= den;
		end else if (state_q == D_STEP) begin
			if (qbit) begin
				rem_q <= HI_W'(diff[ddm_pkg::DEN_W-1:0]);
			end else begin
				rem_q <= HI_W'(trial[ddm_pkg::DEN_W-1:0]);
			end
			lo_q <= {lo_q[ddm_pkg::Q_W-2:0], qbit};
		end
	end

	assign rsp.done = done_q;
	assign rsp.sat  = sat_q;
	assign rsp.quo  = lo_q;

`ifndef SYNTHESIS
	// Done is a single-cycle pulse
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("divider done held for more than one cycle");

	// Remainder stays below the divisor while stepping
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == D_STEP) |-> (rem_q < HI_W'(den_q)))
		else $error("divider remainder not below divisor");

	// A start is only honored when the unit is idle
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == D_CHECK) |-> $past(state_q) == D_IDLE)
		else $error("divider check entered from a busy state");
`endif

endmodule

`default_nettype wire

[src/diff_drive_mixer_with_timeout_unit.sv]
// Top level of the differential drive mixer with command timeout.
// Depends on ddm_pkg, ddm_cfg and ddm_div.
//
//  channel | direction | tdata (low bit up)            | tuser
//  s_*     | in        | lin_vel[15:0], ang_vel[31:16] | opcode
//  m_*     | out       | left_cmd[15:0], right_cmd[31:16] | timed_out
//  cfg_*   | in        | write enable, index, 16-bit data | -
//
// A command beat or a tick that does not publish leaves the unit idle.
// A publishing tick with a stale command or zero max speed goes straight to
// the output state; otherwise it runs one multiply, then per wheel one sum,
// one normalize and a pass through the shared divider, then the output state
// that loads the output register.
// Input ready drops while a publish is worked out and while its result waits
// for the output register. Reset is asynchronous and needs no clearing pass.
`default_nettype none

module diff_drive_mixer_with_timeout_unit #(
	parameter int VEL_FRAC_BITS = ddm_pkg::VEL_FRAC_BITS_DEF
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        s_tvalid,
	output logic                       s_tready,
	input  wire [31:0]                 s_tdata,   // lin_vel, ang_vel
	input  wire                        s_tuser,   // opcode
	output logic                       m_tvalid,
	input  wire                        m_tready,
	output logic [31:0]                m_tdata,   // left_cmd, right_cmd
	output logic                       m_tuser,   // timed_out
	input  wire                        cfg_we,
	input  wire [ddm_pkg::CFG_AW-1:0]  cfg_addr,
	input  wire [ddm_pkg::CFG_DW-1:0]  cfg_wdata
);

	localparam int V_W   = ddm_pkg::VEL_W + VEL_FRAC_BITS + 1;
	localparam int P_W   = ddm_pkg::VEL_W + ddm_pkg::TRACK_W + 1;
	localparam int SUM_W = ((V_W > P_W) ? V_W : P_W) + 1;
	localparam int SH    = 15 - VEL_FRAC_BITS;
	localparam int NUM_W = SUM_W + SH + 1;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_MUL  = 3'd1;
	localparam logic [2:0] S_SUM  = 3'd2;
	localparam logic [2:0] S_NORM = 3'd3;
	localparam logic [2:0] S_DIV  = 3'd4;
	localparam logic [2:0] S_OUT  = 3'd5;

	ddm_pkg::cfg_t     cfg;
	ddm_pkg::div_rsp_t div_rsp;

	logic [2:0]                         state_q;
	logic signed [ddm_pkg::VEL_W-1:0]   lin_held_q;
	logic signed [ddm_pkg::VEL_W-1:0]   ang_held_q;
	logic [ddm_pkg::AGE_W-1:0]          age_q;
	logic                               seen_q;
	logic [ddm_pkg::PER_W-1:0]          period_cnt_q;
	logic                               side_q;
	logic                               neg_q;
	logic                               stale_q;
	logic signed [ddm_pkg::CMD_W-1:0]   left_q;
	logic signed [ddm_pkg::CMD_W-1:0]   right_q;
	logic signed [P_W-1:0]              prod_s1;
	logic signed [SUM_W-1:0]            sum_s2;
	logic [NUM_W-1:0]                   num_next;
	logic                               div_start;
	logic                               m_tvalid_q;
	logic [31:0]                        m_tdata_q;
	logic                               m_tuser_q;

	logic                               in_beat;
	logic [ddm_pkg::AGE_W-1:0]          age_next;
	logic [ddm_pkg::PER_W-1:0]          period_next;
	logic [ddm_pkg::PER_W-1:0]          period_eff;
	logic                               publish;
	logic                               stale_next;
	logic signed [V_W-1:0]              v_scaled;
	logic [SUM_W-1:0]                   mag;
	logic [ddm_pkg::Q_W-1:0]            q_mag;
	logic [ddm_pkg::Q_W-1:0]            q_dz;
	logic signed [ddm_pkg::CMD_W-1:0]   q_signed;
	logic                               out_free;

	ddm_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.addr   (cfg_addr),
		.wdata  (cfg_wdata),
		.cfg    (cfg)
	);

	ddm_div #(
		.NUM_W (NUM_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num_next),
		.den    ({cfg.max_wheel_speed, 1'b0}),
		.rsp    (div_rsp)
	);

	// Handshake and tick bookkeeping
	assign s_tready    = (state_q == S_IDLE);
	assign in_beat     = s_tvalid && s_tready;
	assign out_free    = !m_tvalid_q || m_tready;
	assign age_next    = (age_q == {ddm_pkg::AGE_W{1'b1}}) ? age_q : age_q + 1'b1;
	assign period_next = period_cnt_q + 1'b1;
	assign period_eff  = (cfg.publish_period_ms == '0) ? ddm_pkg::PER_W'(1)
	                                                   : cfg.publish_period_ms;
	assign publish     = (period_next >= period_eff);
	assign stale_next  = !seen_q || (age_next > cfg.stale_limit);
	assign div_start   = (state_q == S_NORM);

	// Wheel numerator: twice the linear speed, plus or minus w times T
	assign v_scaled = {lin_held_q, {(VEL_FRAC_BITS + 1){1'b0}}};
	assign mag      = sum_s2[SUM_W-1] ? SUM_W'(-sum_s2) : SUM_W'(sum_s2);

	// Divider operand: scaled magnitude plus half the divisor rounds half away
	assign num_next = NUM_W'({mag, {SH{1'b0}}}) + NUM_W'(cfg.max_wheel_speed);

	// Clamp, deadzone and sign of the divider result
	assign q_mag    = div_rsp.sat ? ddm_pkg::Q_MAX : div_rsp.quo;
	assign q_dz     = (q_mag < cfg.deadzone) ? '0 : q_mag;
	assign q_signed = neg_q ? -$signed({1'b0, q_dz}) : $signed({1'b0, q_dz});

	// Sequencer and held command state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			lin_held_q   <= '0;
			ang_held_q   <= '0;
			age_q        <= '0;
			seen_q       <= 1'b0;
			period_cnt_q <= '0;
			side_q       <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_beat && s_tuser == ddm_pkg::OP_CMD) begin
						lin_held_q <= s_tdata[15:0];
						ang_held_q <= s_tdata[31:16];
						age_q      <= '0;
						seen_q     <= 1'b1;
					end else if (in_beat) begin
						age_q <= age_next;
						if (publish) begin
							period_cnt_q <= '0;
							side_q       <= 1'b0;
							if (stale_next || cfg.max_wheel_speed == '0) begin
								state_q <= S_OUT;
							end else begin
								state_q <= S_MUL;
							end
						end else begin
							period_cnt_q <= period_next;
						end
					end
				end
				S_MUL:  state_q <= S_SUM;
				S_SUM:  state_q <= S_NORM;
				S_NORM: state_q <= S_DIV;
				S_DIV: begin
					if (div_rsp.done) begin
						if (side_q) begin
							state_q <= S_OUT;
						end else begin
							side_q  <= 1'b1;
							state_q <= S_SUM;
						end
					end
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Arithmetic registers of the publish sequence
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_beat) begin
			stale_q <= stale_next;
			left_q  <= '0;
			right_q <= '0;
		end
		if (state_q == S_MUL) begin
			prod_s1 <= ang_held_q * $signed({1'b0, cfg.wheel_base});
		end
		if (state_q == S_SUM) begin
			if (side_q) begin
				sum_s2 <= SUM_W'(v_scaled) + SUM_W'(prod_s1);
			end else begin
				sum_s2 <= SUM_W'(v_scaled) - SUM_W'(prod_s1);
			end
		end
		if (state_q == S_NORM) begin
			neg_q <= sum_s2[SUM_W-1];
		end
		if (state_q == S_DIV && div_rsp.done) begin
			if (side_q) begin
				right_q <= q_signed;
			end else begin
				left_q <= q_signed;
			end
		end
	end

	// Output register: load the result, hold until the beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == S_OUT && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_OUT && out_free) begin
			m_tdata_q <= {right_q, left_q};
			m_tuser_q <= stale_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

`ifndef SYNTHESIS
	// A stale result carries zero motion
	a_stale_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && m_tuser_q) |-> (m_tdata_q == 32'd0))
		else $error("stale result carries nonzero wheel commands");

	// Divider answers only while the sequencer waits for it
	a_div_owner: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == S_DIV))
		else $error("divider done outside of the wait state");

	// A publishing tick leaves the idle state
	a_publish_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_beat && s_tuser == ddm_pkg::OP_TICK && publish) |=> !s_tready)
		else $error("input still ready after a publishing tick");
`endif

endmodule

`default_nettype wire
